FILE: rtl/core/stable_descending_key_sorter_core_defines.svh
// assertion macros for the stable descending key sorter
// used by the top level, which supplies clk and rst_n in scope
`ifndef STABLE_DESCENDING_KEY_SORTER_CORE_DEFINES_SVH
`define STABLE_DESCENDING_KEY_SORTER_CORE_DEFINES_SVH

// same-cycle implication
`define SDKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SDKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sdks_pkg.sv
// shared types and constants for the stable descending key sorter
// no dependencies
package sdks_pkg;

    localparam int SDKS_CAPACITY = 64;
    localparam int SDKS_COORD_W  = 5;
    localparam int SDKS_SCORE_W  = 16;

    typedef struct packed {
        logic [SDKS_COORD_W-1:0]        row;
        logic [SDKS_COORD_W-1:0]        column;
        logic signed [SDKS_SCORE_W-1:0] score;
    } sdks_rec_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } sdks_ctl_t;

endpackage

FILE: rtl/core/sdks_if.sv
// item channel interfaces for the stable descending key sorter
// depends on sdks_pkg
interface sdks_in_if
    import sdks_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic [SDKS_COORD_W-1:0]        row;
    logic [SDKS_COORD_W-1:0]        column;
    logic signed [SDKS_SCORE_W-1:0] score;
    logic                           last;

    modport source (output valid, row, column, score, last, input ready);
    modport sink   (input valid, row, column, score, last, output ready);
endinterface

interface sdks_out_if
    import sdks_pkg::*;
;
    logic                           valid;
    logic                           ready;
    logic [SDKS_COORD_W-1:0]        out_row;
    logic [SDKS_COORD_W-1:0]        out_column;
    logic signed [SDKS_SCORE_W-1:0] out_score;
    logic                           out_last;

    modport source (output valid, out_row, out_column, out_score, out_last, input ready);
    modport sink   (input valid, out_row, out_column, out_score, out_last, output ready);
endinterface

FILE: rtl/core/stable_descending_key_sorter_core.sv
// Collects candidate records into a row of CAPACITY sorting cells, highest score
// first, equal scores in arrival order. While collecting, one item is taken every
// cycle. The item marked last starts the unload: the stored records leave from
// the head cell one per cycle, slower under back-pressure, with the final one
// flagged, and no item is taken until the row is empty. The unload
// rate is set by the single cell row, which shifts one place per result taken.
// Records arriving while every cell is full are dropped.
// depends on sdks_pkg, sdks_if, sdks_cell and the defines header
`include "stable_descending_key_sorter_core_defines.svh"

module stable_descending_key_sorter_core
    import sdks_pkg::*;
#(
    parameter int CAPACITY = SDKS_CAPACITY
)
(
    input  logic         clk,
    input  logic         rst_n,
    sdks_in_if.sink      cand,
    sdks_out_if.source   ranked
);

    logic      draining_reg;
    logic      draining_next;
    sdks_ctl_t ctl;
    sdks_rec_t new_rec;
    logic      in_take;
    logic      out_take;

    logic      [CAPACITY-1:0] cell_gt;
    logic      [CAPACITY-1:0] cell_valid;
    sdks_rec_t                cell_rec [CAPACITY];

    assign new_rec.row    = cand.row;
    assign new_rec.column = cand.column;
    assign new_rec.score  = cand.score;

    assign cand.ready = !draining_reg;
    assign in_take    = cand.valid && cand.ready;
    assign out_take   = ranked.valid && ranked.ready;

    assign ctl.insert    = in_take && !cell_valid[CAPACITY-1];
    assign ctl.shift_out = out_take;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic      p_gt;
            logic      p_valid;
            sdks_rec_t p_rec;
            logic      n_valid;
            sdks_rec_t n_rec;

            if (i == 0)
            begin : g_head
                assign p_gt    = 1'b0;
                assign p_valid = 1'b1;
                assign p_rec   = new_rec;
            end
            else
            begin : g_body
                assign p_gt    = cell_gt[i-1];
                assign p_valid = cell_valid[i-1];
                assign p_rec   = cell_rec[i-1];
            end

            if (i == CAPACITY-1)
            begin : g_tail
                assign n_valid = 1'b0;
                assign n_rec   = cell_rec[i];
            end
            else
            begin : g_inner
                assign n_valid = cell_valid[i+1];
                assign n_rec   = cell_rec[i+1];
            end

            sdks_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_rec    (new_rec),
                .prev_gt    (p_gt),
                .prev_valid (p_valid),
                .prev_rec   (p_rec),
                .next_valid (n_valid),
                .next_rec   (n_rec),
                .gt         (cell_gt[i]),
                .valid      (cell_valid[i]),
                .rec        (cell_rec[i])
            );
        end
    endgenerate

    always_comb
    begin
        draining_next = draining_reg;
        if (in_take && cand.last)
        begin
            draining_next = 1'b1;
        end
        else if (out_take && !cell_valid[1])
        begin
            draining_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
        end
    end

    assign ranked.valid      = draining_reg && cell_valid[0];
    assign ranked.out_row    = cell_rec[0].row;
    assign ranked.out_column = cell_rec[0].column;
    assign ranked.out_score  = cell_rec[0].score;
    assign ranked.out_last   = !cell_valid[1];

    `SDKS_ASSERT_NOW(a_no_take_while_unloading, ranked.valid, !cand.ready,
        "item taken during unload")
    `SDKS_ASSERT_NOW(a_cells_packed, 1'b1,
        ((cell_valid >> 1) & ~cell_valid) == '0, "gap in cell row")
    `SDKS_ASSERT_NEXT(a_last_starts_unload, in_take && cand.last, ranked.valid,
        "no result after last item")
    `SDKS_ASSERT_NEXT(a_unload_ends, out_take && ranked.out_last,
        cand.ready && cell_valid == '0, "row not empty after final result")

endmodule

FILE: rtl/core/sdks_cell.sv
// one sorting cell: holds one record, takes the new item or its upstream
// neighbor's record on insert, and its downstream neighbor's on unload; uses sdks_pkg
module sdks_cell
    import sdks_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sdks_ctl_t ctl,
    input  sdks_rec_t new_rec,
    input  logic      prev_gt,
    input  logic      prev_valid,
    input  sdks_rec_t prev_rec,
    input  logic      next_valid,
    input  sdks_rec_t next_rec,
    output logic      gt,
    output logic      valid,
    output sdks_rec_t rec
);

    logic      valid_reg;
    logic      valid_next;
    sdks_rec_t rec_reg;
    sdks_rec_t rec_next;

    // strict compare keeps equal scores in arrival order
    assign gt = !valid_reg || ($signed(rec_reg.score) < $signed(new_rec.score));

    always_comb
    begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctl.insert && gt)
        begin
            valid_next = prev_gt ? prev_valid : 1'b1;
            rec_next   = prev_gt ? prev_rec : new_rec;
        end
        else if (ctl.shift_out)
        begin
            valid_next = next_valid;
            rec_next   = next_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign valid = valid_reg;
    assign rec   = rec_reg;

endmodule
